>>> sv/punctuation_tokenizer_defines.svh
// Assertion macros used by the tokenizer top level.
`ifndef PUNCTUATION_TOKENIZER_DEFINES_SVH
`define PUNCTUATION_TOKENIZER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PTOK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PTOK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/ptok_pkg.sv
package ptok_pkg;

  // Width of the running byte offset; it wraps at this width
  localparam int OFS_W = 32;
  // Width of the token start and length fields
  localparam int FLD_W = 32;
  // Tokens one input byte can produce
  localparam int MAX_TOK = 3;
  // Bundles held between scanner and emitter
  localparam int QDEPTH = 2;
  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  localparam logic [FLD_W-1:0] RUN_MAX = '1;

  // Byte codes the scanner tests for
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BTICK  = 8'h60;

  typedef enum logic [4:0] {
    K_LPAREN, K_RPAREN, K_LBRACK, K_RBRACK, K_LBRACE, K_RBRACE,
    K_DOT, K_COMMA, K_COLON, K_SEMI, K_CARET, K_TILDE,
    K_PLUS, K_MINUS, K_STAR, K_SLASH, K_PERCENT, K_AMP,
    K_PIPE, K_EQUAL, K_BANG, K_LESS, K_GREATER,
    K_END, K_STRING, K_OTHER
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [FLD_W-1:0]  start;
    logic [FLD_W-1:0]  length;
  } token_t;

  // All tokens caused by one input byte, slot 0 first
  typedef struct packed {
    logic [1:0]                count;
    token_t [MAX_TOK-1:0]      tok;
  } bundle_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } punct_t;

  // Map a byte to its punctuation kind
  function automatic punct_t punct_lookup(input logic [7:0] b);
    punct_t r;
    r.hit = 1'b1;
    case (b)
      8'h28:   r.kind = K_LPAREN;
      8'h29:   r.kind = K_RPAREN;
      8'h5B:   r.kind = K_LBRACK;
      8'h5D:   r.kind = K_RBRACK;
      8'h7B:   r.kind = K_LBRACE;
      8'h7D:   r.kind = K_RBRACE;
      8'h2E:   r.kind = K_DOT;
      8'h2C:   r.kind = K_COMMA;
      8'h3A:   r.kind = K_COLON;
      8'h3B:   r.kind = K_SEMI;
      8'h5E:   r.kind = K_CARET;
      8'h7E:   r.kind = K_TILDE;
      8'h2B:   r.kind = K_PLUS;
      8'h2D:   r.kind = K_MINUS;
      8'h2A:   r.kind = K_STAR;
      8'h2F:   r.kind = K_SLASH;
      8'h25:   r.kind = K_PERCENT;
      8'h26:   r.kind = K_AMP;
      8'h7C:   r.kind = K_PIPE;
      8'h3D:   r.kind = K_EQUAL;
      8'h21:   r.kind = K_BANG;
      8'h3C:   r.kind = K_LESS;
      8'h3E:   r.kind = K_GREATER;
      default: begin
        r.hit  = 1'b0;
        r.kind = K_OTHER;
      end
    endcase
    return r;
  endfunction

endpackage

>>> sv/punctuation_tokenizer.sv
// Byte-stream tokenizer for C-like source. One byte is accepted per cycle;
// whitespace and comments are skipped, punctuation and other bytes become
// one-byte tokens, quoted text becomes string tokens, and a byte flagged as
// end of input closes any open token and adds an end token, after which
// offsets restart at zero. A byte causes zero to three tokens. The scanner
// takes a byte every cycle while its two-entry token queue has room; the
// output side delivers one token per cycle while out_ready is high, so
// sustained rate is one byte per cycle when each byte yields at most one
// token, and the output port sets the pace otherwise. The first token of a
// byte is registered in the token queue and then in the output register.
`include "punctuation_tokenizer_defines.svh"

module punctuation_tokenizer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  byte_in,
  input  logic                        end_of_input,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [4:0]                  token_kind,
  output logic [ptok_pkg::FLD_W-1:0]  token_start,
  output logic [ptok_pkg::FLD_W-1:0]  token_length,
  output logic                        last_of_run
);
  import ptok_pkg::*;

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  bundle_t wr_bundle;
  bundle_t head;

  ptok_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_in      (byte_in),
    .end_of_input (end_of_input),
    .q_stat       (q_stat),
    .push         (push),
    .bundle       (wr_bundle)
  );

  ptok_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_bundle (wr_bundle),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  ptok_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .last_of_run  (last_of_run)
  );

  // An end-of-input beat always leaves a bundle waiting
  `PTOK_ASSERT_NEXT(a_eoi_queued, in_valid && in_ready && end_of_input, q_stat.valid, "end of input left no tokens")
  // Only defined kinds leave the block
  `PTOK_ASSERT_NOW(a_kind_range, out_valid, token_kind <= K_OTHER, "token kind out of range")
  // The closing end token is the last of its run
  `PTOK_ASSERT_NOW(a_end_last, out_valid && token_kind == K_END && token_length == '0, last_of_run, "closing end token not last")
  // A push into a full queue only happens in a cycle that also pops
  `PTOK_ASSERT_NOW(a_no_overflow, push, !q_stat.full || pop, "token queue overflow")

endmodule

>>> sv/ptok_scan.sv
module ptok_scan (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        byte_in,
  input  logic              end_of_input,
  input  ptok_pkg::q_stat_t q_stat,
  output logic              push,
  output ptok_pkg::bundle_t bundle
);
  import ptok_pkg::*;

  typedef enum logic [2:0] {
    M_NORMAL = 3'd0,
    M_SLASH  = 3'd1,
    M_LINE   = 3'd2,
    M_BLOCK  = 3'd3,
    M_STAR   = 3'd4,
    M_STRING = 3'd5,
    M_ESC    = 3'd6
  } mode_t;

  mode_t            mode, mode_next;
  logic [7:0]       quote_byte, quote_byte_next;
  logic [OFS_W-1:0] token_begin, token_begin_next;
  logic [FLD_W-1:0] run_length, run_length_next;
  logic [OFS_W-1:0] byte_offset, byte_offset_next;

  logic             in_fire;
  logic [1:0]       n;
  logic             do_normal;
  logic [FLD_W-1:0] run_inc;
  punct_t           pk;
  bundle_t          bnd;

  assign in_ready = !q_stat.full;
  assign in_fire  = in_valid && in_ready;

  // Classify the byte and collect the tokens it closes
  always_comb begin
    mode_next        = mode;
    quote_byte_next  = quote_byte;
    token_begin_next = token_begin;
    run_length_next  = run_length;
    byte_offset_next = byte_offset + OFS_W'(1);
    bnd              = '0;
    n                = '0;
    do_normal        = 1'b0;
    run_inc          = (run_length == RUN_MAX) ? run_length : run_length + FLD_W'(1);
    pk               = punct_lookup(byte_in);

    case (mode)
      M_SLASH: begin
        if (byte_in == CH_SLASH) begin
          mode_next = M_LINE;
        end else if (byte_in == CH_STAR) begin
          mode_next = M_BLOCK;
        end else begin
          bnd.tok[n] = '{kind: K_SLASH, start: FLD_W'(token_begin), length: FLD_W'(1)};
          n = n + 2'd1;
          do_normal = 1'b1;
        end
      end
      M_LINE: begin
        if (byte_in == CH_LF) mode_next = M_NORMAL;
      end
      M_BLOCK: begin
        if (byte_in == CH_STAR) mode_next = M_STAR;
      end
      M_STAR: begin
        if (byte_in == CH_SLASH) mode_next = M_NORMAL;
        else if (byte_in != CH_STAR) mode_next = M_BLOCK;
      end
      M_STRING: begin
        run_length_next = run_inc;
        if (byte_in == CH_BSLASH) begin
          mode_next = M_ESC;
        end else if (byte_in == quote_byte) begin
          bnd.tok[n] = '{kind: K_STRING, start: FLD_W'(token_begin), length: run_inc};
          n = n + 2'd1;
          mode_next = M_NORMAL;
        end
      end
      M_ESC: begin
        run_length_next = run_inc;
        mode_next = M_STRING;
      end
      default: do_normal = 1'b1;
    endcase

    // Scan a byte from the normal state
    if (do_normal) begin
      mode_next = M_NORMAL;
      if (byte_in inside {CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF, CH_LF}) begin
        mode_next = M_NORMAL;
      end else if (byte_in == CH_SLASH) begin
        mode_next        = M_SLASH;
        token_begin_next = byte_offset;
      end else if (byte_in inside {CH_DQUOTE, CH_SQUOTE, CH_BTICK}) begin
        mode_next        = M_STRING;
        quote_byte_next  = byte_in;
        token_begin_next = byte_offset;
        run_length_next  = FLD_W'(1);
      end else if (byte_in == CH_NUL) begin
        bnd.tok[n] = '{kind: K_END, start: FLD_W'(byte_offset), length: FLD_W'(1)};
        n = n + 2'd1;
      end else begin
        bnd.tok[n] = '{kind: pk.kind, start: FLD_W'(byte_offset), length: FLD_W'(1)};
        n = n + 2'd1;
      end
    end

    // Close what is open, add the end token, and restart the source
    if (end_of_input) begin
      if (mode_next == M_SLASH) begin
        bnd.tok[n] = '{kind: K_SLASH, start: FLD_W'(token_begin_next), length: FLD_W'(1)};
        n = n + 2'd1;
      end else if (mode_next == M_STRING || mode_next == M_ESC) begin
        bnd.tok[n] = '{kind: K_STRING, start: FLD_W'(token_begin_next),
                       length: run_length_next};
        n = n + 2'd1;
      end
      bnd.tok[n] = '{kind: K_END, start: FLD_W'(byte_offset_next), length: '0};
      n = n + 2'd1;
      mode_next        = M_NORMAL;
      quote_byte_next  = '0;
      token_begin_next = '0;
      run_length_next  = '0;
      byte_offset_next = '0;
    end
    bnd.count = n;
  end

  assign push   = in_fire && (n != 2'd0);
  assign bundle = bnd;

  // Advance scanner state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_NORMAL;
      quote_byte  <= '0;
      token_begin <= '0;
      run_length  <= '0;
      byte_offset <= '0;
    end else if (in_fire) begin
      mode        <= mode_next;
      quote_byte  <= quote_byte_next;
      token_begin <= token_begin_next;
      run_length  <= run_length_next;
      byte_offset <= byte_offset_next;
    end
  end

endmodule

>>> sv/ptok_queue.sv
module ptok_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ptok_pkg::bundle_t wr_bundle,
  input  logic              pop,
  output ptok_pkg::bundle_t head,
  output ptok_pkg::q_stat_t stat
);
  import ptok_pkg::*;

  bundle_t        entries [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   cnt;

  assign head       = entries[rd_ptr];
  assign stat.valid = (cnt != '0);
  assign stat.full  = (cnt == (QAW+1)'(QDEPTH));

  // Store incoming bundles
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_bundle;
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + QAW'(1);
      end
      if (push && !pop) cnt <= cnt + (QAW+1)'(1);
      else if (pop && !push) cnt <= cnt - (QAW+1)'(1);
    end
  end

endmodule

>>> sv/ptok_emit.sv
module ptok_emit (
  input  logic                           clk,
  input  logic                           rst,
  input  ptok_pkg::q_stat_t              q_stat,
  input  ptok_pkg::bundle_t              head,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [4:0]                     token_kind,
  output logic [ptok_pkg::FLD_W-1:0]     token_start,
  output logic [ptok_pkg::FLD_W-1:0]     token_length,
  output logic                           last_of_run
);
  import ptok_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       is_last;
  token_t     cur;

  assign load    = q_stat.valid && (!out_valid || out_ready);
  assign is_last = (idx == head.count - 2'd1);
  assign cur     = head.tok[idx];
  assign pop     = load && is_last;

  // Serialize one token per cycle into the output register while the queue holds tokens and out_ready is high
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= is_last ? 2'd0 : idx + 2'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold payload until the beat is taken
  always_ff @(posedge clk) begin
    if (load) begin
      token_kind   <= cur.kind;
      token_start  <= cur.start;
      token_length <= cur.length;
      last_of_run  <= is_last;
    end
  end

endmodule

>>> tb/punctuation_tokenizer_test.sv
module punctuation_tokenizer_test;
  import ptok_pkg::*;

  localparam int RANDOM_BYTES = 282;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_CAP    = 100;
  localparam string PUNCT_MARKS = "()[]{}.,:;^~+-*/%&|=!<>";

  typedef enum logic [2:0] {
    SCAN_NORMAL, SCAN_SLASH, SCAN_LINE, SCAN_BLOCK,
    SCAN_BLOCK_STAR, SCAN_STRING, SCAN_ESCAPE
  } scan_mode_t;

  typedef struct {
    kind_t       kind;
    logic [31:0] start;
    logic [31:0] len;
    logic        last;
  } token_beat_t;

  typedef struct {
    logic [7:0]  b;
    logic        eoi;
    logic        typed;
    kind_t       kind;
    logic [31:0] start;
    logic [31:0] len;
  } byte_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  byte_in;
  logic        end_of_input;
  logic        out_valid;
  logic        out_ready;
  logic [4:0]  token_kind;
  logic [FLD_W-1:0] token_start;
  logic [FLD_W-1:0] token_length;
  logic        last_of_run;

  // scanner copy kept by the testbench
  scan_mode_t  scan_mode;
  logic [7:0]  open_quote;
  logic [31:0] pending_begin;
  logic [31:0] string_len;
  logic [31:0] next_offset;

  token_beat_t byte_tokens[$];
  token_beat_t expected_tokens[$];

  int  errors;
  int  idle_cycles;
  bit  calm;
  int  ready_stall;

  // directed bytes; typed rows carry the single token they must produce
  byte_row_t dir_rows [28] = '{
    '{8'h28,     1'b0, 1'b1, K_LPAREN, 32'd0, 32'd1},
    '{CH_NUL,    1'b0, 1'b1, K_END,    32'd1, 32'd1},
    '{8'hFF,     1'b0, 1'b1, K_OTHER,  32'd2, 32'd1},
    '{CH_SLASH,  1'b0, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{"a",       1'b0, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{CH_SLASH,  1'b0, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{CH_SLASH,  1'b0, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{CH_LF,     1'b0, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{CH_SLASH,  1'b0, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{CH_STAR,   1'b0, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{CH_SLASH,  1'b0, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{CH_STAR,   1'b0, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{CH_STAR,   1'b0, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{CH_SLASH,  1'b0, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{CH_DQUOTE, 1'b0, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{CH_BSLASH, 1'b0, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{CH_DQUOTE, 1'b0, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{CH_DQUOTE, 1'b0, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{CH_SPACE,  1'b0, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{CH_SQUOTE, 1'b0, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{CH_BTICK,  1'b0, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{CH_SQUOTE, 1'b0, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{CH_SLASH,  1'b0, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{"x",       1'b1, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{CH_BTICK,  1'b0, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{CH_BSLASH, 1'b1, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{CH_SLASH,  1'b0, 1'b0, K_OTHER,  32'd0, 32'd0},
    '{CH_STAR,   1'b1, 1'b1, K_END,    32'd2, 32'd0}
  };

  punctuation_tokenizer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_in      (byte_in),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .last_of_run  (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_CAP) $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic void add_token(input kind_t kind, input logic [31:0] start,
                                    input logic [31:0] len);
    token_beat_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.last  = 1'b0;
    byte_tokens.push_back(t);
  endfunction

  function automatic void clear_scanner();
    scan_mode     = SCAN_NORMAL;
    open_quote    = 8'h00;
    pending_begin = '0;
    string_len    = '0;
    next_offset   = '0;
  endfunction

  // normal-mode handling of one byte
  function automatic void scan_plain(input logic [7:0] b, input logic [31:0] pos);
    kind_t kind;
    kind = K_OTHER;
    if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_VT || b == CH_FF ||
        b == CH_LF)
      return;
    if (b == CH_SLASH) begin
      scan_mode     = SCAN_SLASH;
      pending_begin = pos;
      return;
    end
    if (b == CH_DQUOTE || b == CH_SQUOTE || b == CH_BTICK) begin
      scan_mode     = SCAN_STRING;
      open_quote    = b;
      pending_begin = pos;
      string_len    = 32'd1;
      return;
    end
    if (b == CH_NUL) begin
      add_token(K_END, pos, 32'd1);
      return;
    end
    for (int i = 0; i < PUNCT_MARKS.len(); i++)
      if (PUNCT_MARKS[i] == b) kind = kind_t'(i);
    add_token(kind, pos, 32'd1);
  endfunction

  function automatic void grow_string();
    if (string_len != 32'hFFFF_FFFF) string_len++;
  endfunction

  // advance the scanner copy by one byte, collecting tokens in byte_tokens
  function automatic void scan_byte(input logic [7:0] b, input logic eoi);
    logic [31:0] pos;
    pos         = next_offset;
    next_offset = pos + 32'd1;
    case (scan_mode)
      SCAN_SLASH: begin
        if (b == CH_SLASH) scan_mode = SCAN_LINE;
        else if (b == CH_STAR) scan_mode = SCAN_BLOCK;
        else begin
          add_token(K_SLASH, pending_begin, 32'd1);
          scan_mode = SCAN_NORMAL;
          scan_plain(b, pos);
        end
      end
      SCAN_LINE: begin
        if (b == CH_LF) scan_mode = SCAN_NORMAL;
      end
      SCAN_BLOCK: begin
        if (b == CH_STAR) scan_mode = SCAN_BLOCK_STAR;
      end
      SCAN_BLOCK_STAR: begin
        if (b == CH_SLASH) scan_mode = SCAN_NORMAL;
        else if (b != CH_STAR) scan_mode = SCAN_BLOCK;
      end
      SCAN_STRING: begin
        grow_string();
        if (b == CH_BSLASH) scan_mode = SCAN_ESCAPE;
        else if (b == open_quote) begin
          add_token(K_STRING, pending_begin, string_len);
          scan_mode = SCAN_NORMAL;
        end
      end
      SCAN_ESCAPE: begin
        grow_string();
        scan_mode = SCAN_STRING;
      end
      default: begin
        scan_mode = SCAN_NORMAL;
        scan_plain(b, pos);
      end
    endcase
    // close what is open, then end the source
    if (eoi) begin
      if (scan_mode == SCAN_SLASH) add_token(K_SLASH, pending_begin, 32'd1);
      else if (scan_mode == SCAN_STRING || scan_mode == SCAN_ESCAPE)
        add_token(K_STRING, pending_begin, string_len);
      add_token(K_END, next_offset, 32'd0);
      clear_scanner();
    end
  endfunction

  // drive one input beat, wait for it to be taken, then queue its tokens
  task automatic send_byte(input byte_row_t row);
    int gap;
    token_beat_t t;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    byte_in      <= row.b;
    end_of_input <= row.eoi;
    do @(posedge clk); while (!in_ready);
    byte_tokens.delete();
    scan_byte(row.b, row.eoi);
    if (row.typed) begin
      byte_tokens.delete();
      add_token(row.kind, row.start, row.len);
    end
    if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
    foreach (byte_tokens[i]) begin
      t = byte_tokens[i];
      expected_tokens.push_back(t);
    end
    @(negedge clk);
  endtask

  task automatic send_plain(input logic [7:0] b, input logic eoi);
    byte_row_t row;
    row.b     = b;
    row.eoi   = eoi;
    row.typed = 1'b0;
    row.kind  = K_OTHER;
    row.start = '0;
    row.len   = '0;
    send_byte(row);
  endtask

  // check each output beat against the oldest expected token
  always @(posedge clk) begin : token_check
    token_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("unexpected token kind %0d start %0d", token_kind,
                                  token_start));
      end else begin
        want = expected_tokens.pop_front();
        check_field("token_kind", 32'(token_kind), 32'(want.kind));
        check_field("token_start", token_start, want.start);
        check_field("token_length", token_length, want.len);
        check_field("last_of_run", 32'(last_of_run), 32'(want.last));
      end
    end
  end

  // count cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    idle_cycles = 0;
    @(negedge rst);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // output side: random stalls
  initial begin
    ready_stall = 0;
    out_ready   = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (ready_stall > 0) begin
        out_ready <= 1'b0;
        ready_stall--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) ready_stall = pick_gap();
      end
    end
  end

  initial begin
    int sent;
    int pick;
    int n;
    logic [7:0] quote;
    errors       = 0;
    calm         = 1'b0;
    sent         = 0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    byte_in      = 8'h00;
    end_of_input = 1'b0;
    clear_scanner();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    foreach (dir_rows[i]) send_byte(dir_rows[i]);

    // random source text built from well-formed pieces plus noise
    while (sent < RANDOM_BYTES) begin
      if (sent % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_plain(PUNCT_MARKS[$urandom_range(0, 22)], 1'b0);
        sent++;
      end else if (pick < 35) begin
        case ($urandom_range(0, 5))
          0: send_plain(CH_SPACE, 1'b0);
          1: send_plain(CH_TAB, 1'b0);
          2: send_plain(CH_CR, 1'b0);
          3: send_plain(CH_VT, 1'b0);
          4: send_plain(CH_FF, 1'b0);
          default: send_plain(CH_LF, 1'b0);
        endcase
        sent++;
      end else if (pick < 55) begin
        // quoted text, escapes inside, sometimes left open
        case ($urandom_range(0, 2))
          0: quote = CH_DQUOTE;
          1: quote = CH_SQUOTE;
          default: quote = CH_BTICK;
        endcase
        send_plain(quote, 1'b0);
        n = $urandom_range(0, 6);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 4) == 0) begin
            send_plain(CH_BSLASH, 1'b0);
            sent++;
          end
          send_plain(8'($urandom_range(0, 255)), 1'b0);
        end
        if ($urandom_range(0, 4) != 0) send_plain(quote, 1'b0);
        sent += n + 2;
      end else if (pick < 65) begin
        send_plain(CH_SLASH, 1'b0);
        send_plain(CH_SLASH, 1'b0);
        n = $urandom_range(0, 5);
        for (int k = 0; k < n; k++) send_plain(8'($urandom_range(0, 255)), 1'b0);
        send_plain(CH_LF, 1'b0);
        sent += n + 3;
      end else if (pick < 75) begin
        send_plain(CH_SLASH, 1'b0);
        send_plain(CH_STAR, 1'b0);
        n = $urandom_range(0, 6);
        for (int k = 0; k < n; k++)
          case ($urandom_range(0, 3))
            0: send_plain(CH_STAR, 1'b0);
            1: send_plain(CH_SLASH, 1'b0);
            default: send_plain(8'($urandom_range(0, 255)), 1'b0);
          endcase
        send_plain(CH_STAR, 1'b0);
        send_plain(CH_SLASH, 1'b0);
        sent += n + 4;
      end else if (pick < 85) begin
        send_plain(8'($urandom_range(0, 255)), 1'b0);
        sent++;
      end else if (pick < 90) begin
        send_plain(CH_SLASH, 1'b0);
        send_plain(8'($urandom_range(0, 255)), 1'b0);
        sent += 2;
      end else if (pick < 95) begin
        send_plain(CH_NUL, 1'b0);
        sent++;
      end else begin
        send_plain(8'($urandom_range(0, 255)), 1'b1);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // drain, then keep clocking so the block can still misbehave
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_tokens.size() != 0)
      report_mismatch($sformatf("%0d tokens never arrived", expected_tokens.size()));
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/ptok_pkg.sv
sv/ptok_scan.sv
sv/ptok_queue.sv
sv/ptok_emit.sv
sv/punctuation_tokenizer.sv
tb/punctuation_tokenizer_test.sv
